[sv/e2q_pkg.sv]
package e2q_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int QUAT_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int QF            = QUAT_BITS - 2;
    localparam int ANGLE_SHIFT   = 32 - ANGLE_BITS;

    localparam int CW = 34;
    localparam int PW = 2 * CW;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [PW:0]   t_sum;

    typedef struct packed {
        t_cw c;
        t_cw s;
    } t_cs;

    localparam t_cw PI_Q30      = 34'sd3373259426;
    localparam t_cw HALF_PI_Q30 = 34'sd1686629713;
    localparam t_cw GAIN_Q30    = 34'sd652032874;

    function automatic t_cw atan_q30(input int idx);
        t_cw v;
        case (idx)
            0:       v = 34'sd843314856;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043836;
            3:       v = 34'sd133525158;
            4:       v = 34'sd67021686;
            5:       v = 34'sd33543515;
            6:       v = 34'sd16775850;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194282;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048575;
            11:      v = 34'sd524287;
            12:      v = 34'sd262143;
            13:      v = 34'sd131071;
            14:      v = 34'sd65535;
            15:      v = 34'sd32767;
            16:      v = 34'sd16383;
            17:      v = 34'sd8191;
            18:      v = 34'sd4095;
            19:      v = 34'sd2047;
            20:      v = 34'sd1023;
            21:      v = 34'sd511;
            22:      v = 34'sd255;
            23:      v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/e2q_cordic.sv]
module e2q_cordic
    import e2q_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output logic                         o_valid,
    output t_cs                          o_cs
);

    t_cw  r_x [CORDIC_N+1];
    t_cw  r_y [CORDIC_N+1];
    t_cw  r_z [CORDIC_N+1];
    logic r_neg [CORDIC_N+1];
    logic r_v [CORDIC_N+1];
    logic r_ov;
    t_cs  r_cs;

    t_cw  ang;
    t_cw  n_z;
    logic n_neg;

    // The half angle in Q30 is the input shifted up; then fold into [-pi/2, pi/2].
    always_comb begin
        ang   = t_cw'(i_angle) <<< ANGLE_SHIFT;
        n_z   = ang;
        n_neg = 1'b0;
        if (ang > HALF_PI_Q30) begin
            n_z   = ang - PI_Q30;
            n_neg = 1'b1;
        end else if (ang < -HALF_PI_Q30) begin
            n_z   = ang + PI_Q30;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= n_z;
            r_neg[0] <= n_neg;
        end
    end

    for (genvar g = 0; g < CORDIC_N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[CORDIC_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cs.c <= r_neg[CORDIC_N] ? -r_x[CORDIC_N] : r_x[CORDIC_N];
            r_cs.s <= r_neg[CORDIC_N] ? -r_y[CORDIC_N] : r_y[CORDIC_N];
        end
    end

    assign o_valid = r_ov;
    assign o_cs    = r_cs;

endmodule

[sv/e2q_mult.sv]
module e2q_mult
    import e2q_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_cs  i_yaw,
    input  t_cs  i_pitch,
    input  t_cs  i_roll,
    output logic o_valid,
    output t_sum o_w,
    output t_sum o_x,
    output t_sum o_y,
    output t_sum o_z
);

    localparam t_prod HALF_Q30 = t_prod'(1) <<< 29;

    logic  r_va, r_vb, r_vc;
    t_cw   r_crcp, r_srsp, r_crsp, r_srcp, r_cy, r_sy;
    t_prod r_p [8];
    t_sum  r_w, r_x, r_y, r_z;

    t_prod p_crcp, p_srsp, p_crsp, p_srcp;

    always_comb begin
        p_crcp = t_prod'(i_roll.c) * t_prod'(i_pitch.c) + HALF_Q30;
        p_srsp = t_prod'(i_roll.s) * t_prod'(i_pitch.s) + HALF_Q30;
        p_crsp = t_prod'(i_roll.c) * t_prod'(i_pitch.s) + HALF_Q30;
        p_srcp = t_prod'(i_roll.s) * t_prod'(i_pitch.c) + HALF_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crcp <= CW'(p_crcp >>> 30);
            r_srsp <= CW'(p_srsp >>> 30);
            r_crsp <= CW'(p_crsp >>> 30);
            r_srcp <= CW'(p_srcp >>> 30);
            r_cy   <= i_yaw.c;
            r_sy   <= i_yaw.s;

            r_p[0] <= t_prod'(r_crcp) * t_prod'(r_cy);
            r_p[1] <= t_prod'(r_srsp) * t_prod'(r_sy);
            r_p[2] <= t_prod'(r_crsp) * t_prod'(r_cy);
            r_p[3] <= t_prod'(r_srcp) * t_prod'(r_sy);
            r_p[4] <= t_prod'(r_crcp) * t_prod'(r_sy);
            r_p[5] <= t_prod'(r_srsp) * t_prod'(r_cy);
            r_p[6] <= t_prod'(r_srcp) * t_prod'(r_cy);
            r_p[7] <= t_prod'(r_crsp) * t_prod'(r_sy);

            r_w <= t_sum'(r_p[0]) + t_sum'(r_p[1]);
            r_x <= t_sum'(r_p[2]) + t_sum'(r_p[3]);
            r_y <= t_sum'(r_p[4]) - t_sum'(r_p[5]);
            r_z <= t_sum'(r_p[6]) - t_sum'(r_p[7]);
        end
    end

    assign o_valid = r_vc;
    assign o_w     = r_w;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

[sv/euler_to_quaternion_core.sv]
// Converts yaw, pitch and roll (radians, 13 fraction bits) into a unit quaternion in Q1.14.
// One request is taken every cycle while o_stall is low; a result passes through the CORDIC
// stage chain, the three product stages and the output register. A one-entry skid stage
// behind the output register lets the pipeline keep accepting while a finished result waits
// to be taken; once the skid entry is full, o_stall is raised and the pipeline holds.
module euler_to_quaternion_core
    import e2q_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ANGLE_BITS-1:0] i_yaw_angle,
    input  logic signed [ANGLE_BITS-1:0] i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] i_roll_angle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [QUAT_BITS-1:0]  o_quat_w,
    output logic signed [QUAT_BITS-1:0]  o_quat_x,
    output logic signed [QUAT_BITS-1:0]  o_quat_y,
    output logic signed [QUAT_BITS-1:0]  o_quat_z
);

    typedef logic signed [QUAT_BITS-1:0] t_q;
    typedef struct packed {
        t_q w;
        t_q x;
        t_q y;
        t_q z;
    } t_quat;

    localparam t_sum RND = t_sum'(1) <<< (59 - QF);
    localparam t_sum LIM = t_sum'(1) <<< QF;

    function automatic t_q finish(input t_sum s);
        t_sum v;
        v = (s + RND) >>> (60 - QF);
        if (v > LIM) begin
            v = LIM;
        end
        if (v < -LIM) begin
            v = -LIM;
        end
        return QUAT_BITS'(v);
    endfunction

    logic  en;
    logic  v_yaw, v_pitch, v_roll, v_mul;
    t_cs   cs_yaw, cs_pitch, cs_roll;
    t_sum  s_w, s_x, s_y, s_z;
    t_quat n_res;

    logic  r_ov, r_skid_v;
    t_quat r_out, r_skid;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    e2q_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_angle (i_yaw_angle),
        .o_valid (v_yaw),
        .o_cs    (cs_yaw)
    );

    e2q_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_angle (i_pitch_angle),
        .o_valid (v_pitch),
        .o_cs    (cs_pitch)
    );

    e2q_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_angle (i_roll_angle),
        .o_valid (v_roll),
        .o_cs    (cs_roll)
    );

    e2q_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_yaw & v_pitch & v_roll),
        .i_yaw   (cs_yaw),
        .i_pitch (cs_pitch),
        .i_roll  (cs_roll),
        .o_valid (v_mul),
        .o_w     (s_w),
        .o_x     (s_x),
        .o_y     (s_y),
        .o_z     (s_z)
    );

    always_comb begin
        n_res.w = finish(s_w);
        n_res.x = finish(s_x);
        n_res.y = finish(s_y);
        n_res.z = finish(s_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            if (r_skid_v) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_ov <= v_mul;
            end
        end else if (v_mul) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (en) begin
            r_skid <= n_res;
        end
    end

    assign o_valid  = r_ov;
    assign o_quat_w = r_out.w;
    assign o_quat_x = r_out.x;
    assign o_quat_y = r_out.y;
    assign o_quat_z = r_out.z;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid entry held without a valid output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_ov && i_stall))
        else $error("skid filled while output was free");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (r_ov && !r_skid_v))
        else $error("skid entry not moved to output");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (t_sum'(o_quat_w) <= LIM && t_sum'(o_quat_w) >= -LIM))
        else $error("scalar part beyond unit range");
`endif

endmodule
